// ----- src/bsl_pkg.sv -----
`default_nettype none

package bsl_pkg;

   // fixed widths of the item fields
   localparam int CHAR_W = 8;
   localparam int LINE_W = 24;
   localparam int LEN_W  = 16;

   // defaults for the top level parameters
   localparam int MAX_TOKEN_LEN_DEFAULT = 1024;
   localparam int QUEUE_DEPTH_DEFAULT   = 4;

   // token classes
   localparam logic [1:0] CLASS_WORD   = 2'd0;
   localparam logic [1:0] CLASS_PUNCT  = 2'd1;
   localparam logic [1:0] CLASS_STRING = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_TOO_LONG   = 3'd1;
   localparam logic [2:0] ERR_END_IN_STR = 3'd2;
   localparam logic [2:0] ERR_NL_IN_STR  = 3'd3;
   localparam logic [2:0] ERR_BAD_ESCAPE = 3'd4;

   // characters the lexer reacts to
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_VT     = 8'h0B;
   localparam logic [7:0] CHAR_FF     = 8'h0C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_WORD    = 3'd2,
      MODE_STRING  = 3'd3,
      MODE_ESCAPE  = 3'd4
   } mode_type;

   // one result item without line number and last flag
   typedef struct packed {
      logic              has_char;
      logic [CHAR_W-1:0] char_value;
      logic              token_done;
      logic [1:0]        token_class;
      logic              at_end;
      logic [2:0]        error_code;
   } result_type;

   // everything one input item produces, as queued between front and back
   typedef struct packed {
      logic              two;
      logic [LINE_W-1:0] line;
      result_type        res0;
      result_type        res1;
   } record_type;

   typedef struct packed {
      logic       valid;
      record_type rec;
   } push_type;

endpackage

`default_nettype wire

// ----- src/bsl_front.sv -----
`default_nettype none

module bsl_front #(
   parameter int MAX_TOKEN_LEN = bsl_pkg::MAX_TOKEN_LEN_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [bsl_pkg::CHAR_W-1:0] data_byte,
   input  wire logic                     end_of_text,
   output bsl_pkg::push_type             push_out
);
   import bsl_pkg::*;

   localparam logic [LEN_W-1:0] WORD_LIMIT = LEN_W'(MAX_TOKEN_LEN);
   localparam logic [LEN_W-1:0] STR_LIMIT  = LEN_W'(MAX_TOKEN_LEN - 1);
   localparam logic [LINE_W-1:0] LINE_ONE  = LINE_W'(1);

   mode_type          mode_ff, mode_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              halt_ff, halt_in;

   logic       is_space;
   logic       word_stop;
   logic       line_inc;

   // between-token decode of the current byte
   logic       i_emit;
   result_type i_res;
   mode_type   i_mode;
   logic [LEN_W-1:0] i_len;
   logic       i_inc;

   logic       emit0, emit1;
   result_type res0, res1;
   logic [CHAR_W-1:0] decoded;

   assign is_space = (data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB) ||
                     (data_byte == CHAR_NL) || (data_byte == CHAR_VT) ||
                     (data_byte == CHAR_FF) || (data_byte == CHAR_CR);

   assign word_stop = end_of_text || is_space || (data_byte == CHAR_LBRACE) ||
                      (data_byte == CHAR_RBRACE) || (data_byte == CHAR_QUOTE) ||
                      (data_byte == CHAR_HASH);

   always_comb begin
      i_emit = 1'b0;
      i_res  = '0;
      i_mode = MODE_IDLE;
      i_len  = '0;
      i_inc  = 1'b0;
      if (end_of_text) begin
         i_emit       = 1'b1;
         i_res.at_end = 1'b1;
      end else if (is_space) begin
         i_inc = (data_byte == CHAR_NL);
      end else if (data_byte == CHAR_HASH) begin
         i_mode = MODE_COMMENT;
      end else if ((data_byte == CHAR_RBRACE) || (data_byte == CHAR_SEMI) ||
                   (data_byte == CHAR_RPAREN)) begin
         i_emit            = 1'b1;
         i_res.has_char    = 1'b1;
         i_res.char_value  = data_byte;
         i_res.token_done  = 1'b1;
         i_res.token_class = CLASS_PUNCT;
      end else if (data_byte == CHAR_QUOTE) begin
         i_emit            = 1'b1;
         i_res.has_char    = 1'b1;
         i_res.char_value  = data_byte;
         i_res.token_class = CLASS_STRING;
         i_len             = LEN_W'(1);
         i_mode            = MODE_STRING;
      end else begin
         i_emit            = 1'b1;
         i_res.has_char    = 1'b1;
         i_res.char_value  = data_byte;
         i_res.token_class = CLASS_WORD;
         i_len             = LEN_W'(1);
         i_mode            = MODE_WORD;
      end
   end

   // escape decoding
   always_comb begin
      case (data_byte)
         CHAR_N:  decoded = CHAR_NL;
         CHAR_T:  decoded = CHAR_TAB;
         default: decoded = data_byte;
      endcase
   end

   // next state
   always_comb begin
      mode_in  = mode_ff;
      len_in   = len_ff;
      halt_in  = halt_ff;
      line_inc = 1'b0;
      if (accept && !halt_ff) begin
         unique case (mode_ff)
            MODE_COMMENT: begin
               if (end_of_text) begin
                  mode_in = MODE_IDLE;
               end else if (data_byte == CHAR_NL) begin
                  mode_in  = MODE_IDLE;
                  line_inc = 1'b1;
               end
            end
            MODE_WORD: begin
               if (word_stop) begin
                  mode_in  = i_mode;
                  len_in   = i_len;
                  line_inc = i_inc;
               end else if (len_ff >= WORD_LIMIT) begin
                  halt_in = 1'b1;
               end else begin
                  len_in = len_ff + LEN_W'(1);
               end
            end
            MODE_STRING, MODE_ESCAPE: begin
               if (end_of_text || (data_byte == CHAR_NL)) begin
                  halt_in = 1'b1;
               end else if ((mode_ff == MODE_STRING) && (data_byte == CHAR_QUOTE)) begin
                  mode_in = MODE_IDLE;
                  len_in  = '0;
               end else if ((mode_ff == MODE_STRING) && (data_byte == CHAR_BSLASH)) begin
                  mode_in = MODE_ESCAPE;
               end else if ((mode_ff == MODE_ESCAPE) && (data_byte != CHAR_N) &&
                            (data_byte != CHAR_T) && (data_byte != CHAR_QUOTE) &&
                            (data_byte != CHAR_BSLASH)) begin
                  halt_in = 1'b1;
               end else if (len_ff >= STR_LIMIT) begin
                  halt_in = 1'b1;
               end else begin
                  mode_in = MODE_STRING;
                  len_in  = len_ff + LEN_W'(1);
               end
            end
            default: begin
               mode_in  = i_mode;
               len_in   = i_len;
               line_inc = i_inc;
            end
         endcase
      end
      line_in = (line_inc && (line_ff != '1)) ? line_ff + LINE_ONE : line_ff;
   end

   // results
   always_comb begin
      emit0 = 1'b0;
      emit1 = 1'b0;
      res0  = '0;
      res1  = '0;
      unique case (mode_ff)
         MODE_COMMENT: begin
            if (end_of_text) begin
               emit0       = 1'b1;
               res0.at_end = 1'b1;
            end
         end
         MODE_WORD: begin
            if (word_stop) begin
               emit0           = 1'b1;
               res0.token_done = 1'b1;
               emit1           = i_emit;
               res1            = i_res;
            end else if (len_ff >= WORD_LIMIT) begin
               emit0           = 1'b1;
               res0.error_code = ERR_TOO_LONG;
            end else begin
               emit0           = 1'b1;
               res0.has_char   = 1'b1;
               res0.char_value = data_byte;
            end
         end
         MODE_STRING, MODE_ESCAPE: begin
            emit0            = 1'b1;
            res0.token_class = CLASS_STRING;
            if (end_of_text) begin
               res0.error_code = ERR_END_IN_STR;
            end else if (data_byte == CHAR_NL) begin
               res0.error_code = ERR_NL_IN_STR;
            end else if ((mode_ff == MODE_STRING) && (data_byte == CHAR_QUOTE)) begin
               res0.has_char   = 1'b1;
               res0.char_value = data_byte;
               res0.token_done = 1'b1;
            end else if ((mode_ff == MODE_STRING) && (data_byte == CHAR_BSLASH)) begin
               emit0 = 1'b0;
            end else if ((mode_ff == MODE_ESCAPE) && (data_byte != CHAR_N) &&
                         (data_byte != CHAR_T) && (data_byte != CHAR_QUOTE) &&
                         (data_byte != CHAR_BSLASH)) begin
               res0.error_code = ERR_BAD_ESCAPE;
            end else if (len_ff >= STR_LIMIT) begin
               res0.error_code = ERR_TOO_LONG;
            end else begin
               res0.has_char   = 1'b1;
               res0.char_value = (mode_ff == MODE_ESCAPE) ? decoded : data_byte;
            end
         end
         default: begin
            emit0 = i_emit;
            res0  = i_res;
         end
      endcase
   end

   assign push_out.valid    = accept && !halt_ff && emit0;
   assign push_out.rec.two  = emit1;
   assign push_out.rec.line = line_ff;
   assign push_out.rec.res0 = res0;
   assign push_out.rec.res1 = res1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         line_ff <= LINE_ONE;
         len_ff  <= '0;
         halt_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         len_ff  <= len_in;
         halt_ff <= halt_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/bsl_queue.sv -----
`default_nettype none

module bsl_queue #(
   parameter int DEPTH = bsl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire bsl_pkg::push_type          push_in,
   output logic                            full,
   output logic                            empty,
   input  wire logic                       pop,
   output bsl_pkg::result_type             head_res,
   output logic [bsl_pkg::LINE_W-1:0]      head_line,
   output logic                            head_last
);
   import bsl_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   record_type        rec_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              slot_ff, slot_in;

   record_type head;
   logic       do_push, do_pop, take;

   assign full  = (count_ff == CNT_FULL);
   assign empty = (count_ff == '0);

   assign head      = rec_ff[rd_ptr_ff];
   assign head_res  = slot_ff ? head.res1 : head.res0;
   assign head_line = head.line;
   assign head_last = slot_ff || !head.two;

   // a record leaves once its last result is taken
   assign take    = pop && !empty;
   assign do_pop  = take && head_last;
   assign do_push = push_in.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      slot_in   = slot_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (take) begin
         slot_in = !head_last;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         rec_ff[wr_ptr_ff] <= push_in.rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         slot_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         slot_ff   <= slot_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/byte_stream_lexer_core.sv -----
// channel   direction  handshake              payload
// req       in         push / full            req_data_byte, req_end_of_text
// rsp       out        empty / pop            rsp_has_char .. rsp_last
//
// one input item is taken per cycle while full is low; the lexer mode update
// is a single cycle of logic, so the front never holds an item back itself
// an item yields zero, one or two result items; they go into a small record
// queue and leave one per cycle while pop is high, so a run of two-result items
// is limited by the result side to one result item per cycle
// a result item reaches the rsp ports from the registered record queue, behind earlier records
// reset is synchronous: lexer between tokens, line 1, queue empty
// either side may stall on its own; full rises only when the queue is full
`default_nettype none

module byte_stream_lexer_core #(
   parameter int MAX_TOKEN_LEN = bsl_pkg::MAX_TOKEN_LEN_DEFAULT,
   parameter int QUEUE_DEPTH   = bsl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // input channel
   input  wire logic                         push,
   output logic                              full,
   input  wire logic [bsl_pkg::CHAR_W-1:0]   req_data_byte,
   input  wire logic                         req_end_of_text,
   // result channel
   output logic                              empty,
   input  wire logic                         pop,
   output logic                              rsp_has_char,
   output logic [bsl_pkg::CHAR_W-1:0]        rsp_char_value,
   output logic                              rsp_token_done,
   output logic [1:0]                        rsp_token_class,
   output logic                              rsp_at_end,
   output logic [2:0]                        rsp_error_code,
   output logic [bsl_pkg::LINE_W-1:0]        rsp_line_number,
   output logic                              rsp_last
);
   import bsl_pkg::*;

   logic       accept;
   push_type   push_rec;
   result_type head_res;

   // item taken this edge
   assign accept = push && !full;

   // front: mode, line and length tracking, builds at most one record per item
   bsl_front #(
      .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .end_of_text (req_end_of_text),
      .push_out    (push_rec)
   );

   // back: record queue, hands out the results of a record one by one
   bsl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push_rec),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .head_res  (head_res),
      .head_line (rsp_line_number),
      .head_last (rsp_last)
   );

   // unpack the head result onto the ports
   assign rsp_has_char    = head_res.has_char;
   assign rsp_char_value  = head_res.char_value;
   assign rsp_token_done  = head_res.token_done;
   assign rsp_token_class = head_res.token_class;
   assign rsp_at_end      = head_res.at_end;
   assign rsp_error_code  = head_res.error_code;

endmodule

`default_nettype wire

// ----- src/bsl_checker.sv -----
`default_nettype none

module bsl_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       push,
   input wire logic                       full,
   input wire logic [bsl_pkg::CHAR_W-1:0] req_data_byte,
   input wire logic                       req_end_of_text,
   input wire logic                       empty,
   input wire logic                       pop,
   input wire logic                       rsp_has_char,
   input wire logic [bsl_pkg::CHAR_W-1:0] rsp_char_value,
   input wire logic                       rsp_token_done,
   input wire logic [1:0]                 rsp_token_class,
   input wire logic                       rsp_at_end,
   input wire logic [2:0]                 rsp_error_code,
   input wire logic [bsl_pkg::LINE_W-1:0] rsp_line_number,
   input wire logic                       rsp_last
);
   import bsl_pkg::*;

   // queue comes out of reset empty and open
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queue not cleared by reset");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_char_value) &&
                            $stable(rsp_has_char) && $stable(rsp_last) &&
                            $stable(rsp_error_code) && $stable(rsp_line_number)))
      else $error("result changed while stalled");

   // end of input carries no character, no token end and no error, with class word
   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_at_end) |-> (!rsp_has_char && !rsp_token_done &&
                                  rsp_token_class == CLASS_WORD &&
                                  rsp_error_code == ERR_NONE))
      else $error("malformed end result");

   // an error is always the only and final result of its item
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_error_code != ERR_NONE) |-> (rsp_last && !rsp_has_char))
      else $error("error result not final");

   // line counting starts at one and saturates
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_line_number != '0))
      else $error("line number zero");

endmodule

bind byte_stream_lexer_core bsl_checker u_bsl_checker (.*);

`default_nettype wire

// ----- verif/token_stream_checker.sv -----
module token_stream_checker
   import bsl_pkg::*;
#(
   parameter int MAX_LEN = MAX_TOKEN_LEN_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic              full,
   input  wire logic [CHAR_W-1:0] req_data_byte,
   input  wire logic              req_end_of_text,
   input  wire logic              empty,
   input  wire logic              pop,
   input  wire logic              rsp_has_char,
   input  wire logic [CHAR_W-1:0] rsp_char_value,
   input  wire logic              rsp_token_done,
   input  wire logic [1:0]        rsp_token_class,
   input  wire logic              rsp_at_end,
   input  wire logic [2:0]        rsp_error_code,
   input  wire logic [LINE_W-1:0] rsp_line_number,
   input  wire logic              rsp_last,
   output int                     mismatches,
   output int                     results_due
);

   typedef struct packed {
      logic              has_char;
      logic [CHAR_W-1:0] char_value;
      logic              token_done;
      logic [1:0]        token_class;
      logic              at_end;
      logic [2:0]        error_code;
      logic [LINE_W-1:0] line_number;
      logic              last;
   } lex_out_type;

   // lexer state as the predictor sees it
   mode_type          lx_mode = MODE_IDLE;
   logic [LINE_W-1:0] line_cnt = LINE_W'(1);
   logic [LEN_W-1:0]  tok_len = '0;
   logic              halted = 1'b0;

   lex_out_type token_queue[$];
   lex_out_type new_res[2];
   int          new_n = 0;
   int          err_cnt = 0;

   function automatic logic is_ws(input logic [CHAR_W-1:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NL || c == CHAR_VT
         || c == CHAR_FF || c == CHAR_CR;
   endfunction

   task automatic add_res(input logic h, input logic [CHAR_W-1:0] c, input logic done,
                          input logic [1:0] cls, input logic fin, input logic [2:0] err);
      lex_out_type r;
      r.has_char    = h;
      r.char_value  = c;
      r.token_done  = done;
      r.token_class = cls;
      r.at_end      = fin;
      r.error_code  = err;
      r.line_number = line_cnt;
      r.last        = 1'b0;
      if (new_n < 2) begin
         new_res[new_n] = r;
         new_n++;
      end
   endtask

   task automatic stop_on(input logic [1:0] cls, input logic [2:0] err);
      add_res(1'b0, 8'h00, 1'b0, cls, 1'b0, err);
      halted = 1'b1;
   endtask

   task automatic between_tokens(input logic [CHAR_W-1:0] c, input logic eot);
      if (eot) begin
         add_res(1'b0, 8'h00, 1'b0, CLASS_WORD, 1'b1, ERR_NONE);
      end else if (is_ws(c)) begin
         if (c == CHAR_NL && line_cnt != '1) begin
            line_cnt = line_cnt + LINE_W'(1);
         end
      end else if (c == CHAR_HASH) begin
         lx_mode = MODE_COMMENT;
      end else if (c == CHAR_RBRACE || c == CHAR_SEMI || c == CHAR_RPAREN) begin
         add_res(1'b1, c, 1'b1, CLASS_PUNCT, 1'b0, ERR_NONE);
      end else if (c == CHAR_QUOTE) begin
         add_res(1'b1, c, 1'b0, CLASS_STRING, 1'b0, ERR_NONE);
         tok_len = LEN_W'(1);
         lx_mode = MODE_STRING;
      end else begin
         add_res(1'b1, c, 1'b0, CLASS_WORD, 1'b0, ERR_NONE);
         tok_len = LEN_W'(1);
         lx_mode = MODE_WORD;
      end
   endtask

   // expected result items of one accepted input item
   task automatic lex_item(input logic [CHAR_W-1:0] c, input logic eot);
      logic              esc;
      logic              ok;
      logic [CHAR_W-1:0] v;
      new_n = 0;
      if (!halted) begin
         case (lx_mode)
            MODE_COMMENT: begin
               if (eot) begin
                  lx_mode = MODE_IDLE;
                  add_res(1'b0, 8'h00, 1'b0, CLASS_WORD, 1'b1, ERR_NONE);
               end else if (c == CHAR_NL) begin
                  lx_mode = MODE_IDLE;
                  if (line_cnt != '1) begin
                     line_cnt = line_cnt + LINE_W'(1);
                  end
               end
            end
            MODE_WORD: begin
               if (eot || is_ws(c) || c == CHAR_LBRACE || c == CHAR_RBRACE
                   || c == CHAR_QUOTE || c == CHAR_HASH) begin
                  add_res(1'b0, 8'h00, 1'b1, CLASS_WORD, 1'b0, ERR_NONE);
                  lx_mode = MODE_IDLE;
                  tok_len = '0;
                  between_tokens(c, eot);
               end else if (int'(tok_len) >= MAX_LEN) begin
                  stop_on(CLASS_WORD, ERR_TOO_LONG);
               end else begin
                  add_res(1'b1, c, 1'b0, CLASS_WORD, 1'b0, ERR_NONE);
                  tok_len = tok_len + LEN_W'(1);
               end
            end
            MODE_STRING, MODE_ESCAPE: begin
               esc = (lx_mode == MODE_ESCAPE);
               v = c;
               if (eot) begin
                  stop_on(CLASS_STRING, ERR_END_IN_STR);
               end else if (c == CHAR_NL) begin
                  stop_on(CLASS_STRING, ERR_NL_IN_STR);
               end else if (!esc && c == CHAR_QUOTE) begin
                  add_res(1'b1, c, 1'b1, CLASS_STRING, 1'b0, ERR_NONE);
                  lx_mode = MODE_IDLE;
                  tok_len = '0;
               end else if (!esc && c == CHAR_BSLASH) begin
                  lx_mode = MODE_ESCAPE;
               end else begin
                  ok = 1'b1;
                  if (esc) begin
                     if (c == CHAR_N) begin
                        v = CHAR_NL;
                     end else if (c == CHAR_T) begin
                        v = CHAR_TAB;
                     end else if (c != CHAR_QUOTE && c != CHAR_BSLASH) begin
                        ok = 1'b0;
                     end
                     // bad escape wins over the length check
                     if (ok) begin
                        lx_mode = MODE_STRING;
                     end else begin
                        stop_on(CLASS_STRING, ERR_BAD_ESCAPE);
                     end
                  end
                  if (ok) begin
                     if (int'(tok_len) + 1 >= MAX_LEN) begin
                        stop_on(CLASS_STRING, ERR_TOO_LONG);
                     end else begin
                        add_res(1'b1, v, 1'b0, CLASS_STRING, 1'b0, ERR_NONE);
                        tok_len = tok_len + LEN_W'(1);
                     end
                  end
               end
            end
            default: begin
               lx_mode = MODE_IDLE;
               between_tokens(c, eot);
            end
         endcase
      end
      if (new_n > 0) begin
         new_res[new_n-1].last = 1'b1;
      end
      for (int i = 0; i < new_n; i++) begin
         token_queue.push_back(new_res[i]);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want != got) begin
         err_cnt++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      lex_out_type want;
      if (reset) begin
         lx_mode  = MODE_IDLE;
         line_cnt = LINE_W'(1);
         tok_len  = '0;
         halted   = 1'b0;
         token_queue.delete();
      end else begin
         if (push && !full) begin
            lex_item(req_data_byte, req_end_of_text);
         end
         if (pop && !empty) begin
            if (token_queue.size() == 0) begin
               err_cnt++;
               $display("%0t: unexpected result item, expected none got char %h err %0d",
                        $time, rsp_char_value, rsp_error_code);
            end else begin
               want = token_queue.pop_front();
               check_field("has_char", 32'(want.has_char), 32'(rsp_has_char));
               check_field("char_value", 32'(want.char_value), 32'(rsp_char_value));
               check_field("token_done", 32'(want.token_done), 32'(rsp_token_done));
               check_field("token_class", 32'(want.token_class), 32'(rsp_token_class));
               check_field("at_end", 32'(want.at_end), 32'(rsp_at_end));
               check_field("error_code", 32'(want.error_code), 32'(rsp_error_code));
               check_field("line_number", 32'(want.line_number), 32'(rsp_line_number));
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
      end
      mismatches  <= err_cnt;
      results_due <= token_queue.size();
   end

endmodule

// ----- verif/testbench.sv -----
module testbench;
   import bsl_pkg::*;

   // small token limit so the limit and overflow cases stay short
   localparam int TOKEN_LIMIT  = 64;
   // token bytes in the random part before the boundary and error phases
   localparam int RANDOM_ITEMS = 900;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 600000;

   typedef enum int {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_TOGGLE} pop_style_type;
   typedef enum int {
      FAULT_WORD_LONG, FAULT_STRING_LONG, FAULT_END_IN_STRING, FAULT_NL_IN_STRING,
      FAULT_BAD_ESCAPE
   } fault_kind_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic [CHAR_W-1:0] req_data_byte = '0;
   logic              req_end_of_text = 1'b0;
   logic              pop = 1'b0;

   logic              full;
   logic              empty;
   logic              rsp_has_char;
   logic [CHAR_W-1:0] rsp_char_value;
   logic              rsp_token_done;
   logic [1:0]        rsp_token_class;
   logic              rsp_at_end;
   logic [2:0]        rsp_error_code;
   logic [LINE_W-1:0] rsp_line_number;
   logic              rsp_last;

   int mismatches;
   int results_due;

   byte_stream_lexer_core #(
      .MAX_TOKEN_LEN(TOKEN_LIMIT)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data_byte  (req_data_byte),
      .req_end_of_text(req_end_of_text),
      .empty          (empty),
      .pop            (pop),
      .rsp_has_char   (rsp_has_char),
      .rsp_char_value (rsp_char_value),
      .rsp_token_done (rsp_token_done),
      .rsp_token_class(rsp_token_class),
      .rsp_at_end     (rsp_at_end),
      .rsp_error_code (rsp_error_code),
      .rsp_line_number(rsp_line_number),
      .rsp_last       (rsp_last)
   );

   // watches both channels, predicts and compares
   token_stream_checker #(
      .MAX_LEN(TOKEN_LIMIT)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data_byte  (req_data_byte),
      .req_end_of_text(req_end_of_text),
      .empty          (empty),
      .pop            (pop),
      .rsp_has_char   (rsp_has_char),
      .rsp_char_value (rsp_char_value),
      .rsp_token_done (rsp_token_done),
      .rsp_token_class(rsp_token_class),
      .rsp_at_end     (rsp_at_end),
      .rsp_error_code (rsp_error_code),
      .rsp_line_number(rsp_line_number),
      .rsp_last       (rsp_last),
      .mismatches     (mismatches),
      .results_due    (results_due)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop if the run hangs
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // receiver: changing pop styles, plus a long hold-off on request
   logic          hold_toggle = 1'b0;
   logic          hold_seen = 1'b0;
   int            hold_left = 0;
   int            style_left = 0;
   pop_style_type pop_style = POP_ALWAYS;

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
         // hold-off requested by the sender side, counted here
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
         pop <= 1'b0;
      end else begin
         if (style_left == 0) begin
            pop_style  = pop_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(10, 150);
         end
         style_left--;
         case (pop_style)
            POP_ALWAYS: pop <= 1'b1;
            POP_COIN:   pop <= 1'($urandom_range(0, 1));
            POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
            default:    pop <= ~pop;
         endcase
      end
   end

   // sender state
   int   burst_left = 0;
   int   token_bytes = 0;
   logic after_word = 1'b0;

   function automatic logic is_ws(input logic [CHAR_W-1:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NL || c == CHAR_VT
         || c == CHAR_FF || c == CHAR_CR;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_space();
      case ($urandom_range(0, 5))
         0:       return CHAR_SPACE;
         1:       return CHAR_TAB;
         2:       return CHAR_NL;
         3:       return CHAR_VT;
         4:       return CHAR_FF;
         default: return CHAR_CR;
      endcase
   endfunction

   // a byte that opens a word (first) or keeps one going
   function automatic logic [CHAR_W-1:0] pick_word_byte(input logic first);
      logic [CHAR_W-1:0] b;
      logic              bad;
      do begin
         b = 8'($urandom_range(0, 255));
         bad = is_ws(b) || b == CHAR_HASH || b == CHAR_RBRACE || b == CHAR_QUOTE;
         if (first) begin
            bad = bad || b == CHAR_SEMI || b == CHAR_RPAREN;
         end else begin
            bad = bad || b == CHAR_LBRACE;
         end
      end while (bad);
      return b;
   endfunction

   // a plain byte inside a string
   function automatic logic [CHAR_W-1:0] pick_string_byte();
      logic [CHAR_W-1:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == CHAR_NL || b == CHAR_QUOTE || b == CHAR_BSLASH);
      return b;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_escape();
      case ($urandom_range(0, 3))
         0:       return CHAR_N;
         1:       return CHAR_T;
         2:       return CHAR_QUOTE;
         default: return CHAR_BSLASH;
      endcase
   endfunction

   // offer one item; bursts with random gaps, returns once it is taken
   task automatic send_item(input logic [CHAR_W-1:0] b, input logic eot);
      int gap;
      int roll;
      if (burst_left == 0) begin
         roll = $urandom_range(0, 9);
         if (roll < 3) begin
            gap = 0;
         end else if (roll < 9) begin
            gap = $urandom_range(1, 4);
         end else begin
            gap = $urandom_range(10, 20);
         end
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      push <= 1'b1;
      req_data_byte <= b;
      req_end_of_text <= eot;
      do @(posedge clock); while (full);
   endtask

   // sender holds off until the checker has nothing left to see
   task automatic wait_drained();
      push <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   // first byte of a token: split it from a word still open if it would run on
   task automatic begin_token(input logic [CHAR_W-1:0] b, input logic eot);
      if (after_word && !eot && !is_ws(b) && b != CHAR_LBRACE && b != CHAR_RBRACE
          && b != CHAR_QUOTE && b != CHAR_HASH) begin
         send_item(pick_space(), 1'b0);
      end
      after_word = 1'b0;
      send_item(b, eot);
   endtask

   task automatic gen_word(input int len);
      begin_token(pick_word_byte(1'b1), 1'b0);
      for (int i = 1; i < len; i++) begin
         send_item(pick_word_byte(1'b0), 1'b0);
      end
      after_word = 1'b1;
      token_bytes += len;
   endtask

   // opening quote and len decoded characters, closing quote if asked
   task automatic gen_string(input int len, input logic close);
      begin_token(CHAR_QUOTE, 1'b0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            send_item(CHAR_BSLASH, 1'b0);
            send_item(pick_escape(), 1'b0);
         end else begin
            send_item(pick_string_byte(), 1'b0);
         end
      end
      if (close) begin
         send_item(CHAR_QUOTE, 1'b0);
      end
      token_bytes += len + 2;
   endtask

   task automatic gen_comment(input int len);
      logic [CHAR_W-1:0] b;
      begin_token(CHAR_HASH, 1'b0);
      for (int i = 0; i < len; i++) begin
         do begin
            b = 8'($urandom_range(0, 255));
         end while (b == CHAR_NL);
         send_item(b, 1'b0);
      end
      // a comment ends on newline or on end of input
      if ($urandom_range(0, 3) == 0) begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         send_item(CHAR_NL, 1'b0);
      end
   endtask

   // loose bytes with no quote, so no string and no error can start;
   // the trailing newline closes any word or comment they left open
   task automatic gen_noise(input int len);
      logic [CHAR_W-1:0] b;
      begin_token(CHAR_SPACE, 1'b0);
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         if (b == CHAR_QUOTE) begin
            b = 8'h78;
         end
         send_item(b, ($urandom_range(0, 15) == 0));
      end
      send_item(CHAR_NL, 1'b0);
      token_bytes += len;
   endtask

   task automatic random_token();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         gen_word($urandom_range(1, 12));
      end else if (pick < 55) begin
         gen_string($urandom_range(0, 10), 1'b1);
      end else if (pick < 70) begin
         case ($urandom_range(0, 2))
            0:       begin_token(CHAR_RBRACE, 1'b0);
            1:       begin_token(CHAR_SEMI, 1'b0);
            default: begin_token(CHAR_RPAREN, 1'b0);
         endcase
         token_bytes++;
      end else if (pick < 80) begin
         repeat ($urandom_range(1, 3)) begin_token(pick_space(), 1'b0);
      end else if (pick < 88) begin
         gen_comment($urandom_range(0, 8));
      end else if (pick < 93) begin
         begin_token(8'($urandom_range(0, 255)), 1'b1);
         token_bytes++;
      end else begin
         gen_noise($urandom_range(4, 16));
      end
   endtask

   // errors stick until reset, and reset comes only once: one fault ends the run
   task automatic raise_fault();
      fault_kind_type    kind;
      logic [CHAR_W-1:0] b;
      kind = fault_kind_type'($urandom_range(0, 4));
      case (kind)
         FAULT_WORD_LONG: begin
            gen_word(TOKEN_LIMIT + 1);
         end
         FAULT_STRING_LONG: begin
            gen_string(TOKEN_LIMIT - 2, 1'b0);
            // the overflowing character may come from an escape
            if ($urandom_range(0, 1) == 1) begin
               send_item(CHAR_BSLASH, 1'b0);
               send_item(pick_escape(), 1'b0);
            end else begin
               send_item(pick_string_byte(), 1'b0);
            end
         end
         FAULT_END_IN_STRING, FAULT_NL_IN_STRING: begin
            gen_string($urandom_range(0, 5), 1'b0);
            // also right after a backslash
            if ($urandom_range(0, 1) == 1) begin
               send_item(CHAR_BSLASH, 1'b0);
            end
            if (kind == FAULT_END_IN_STRING) begin
               send_item(8'($urandom_range(0, 255)), 1'b1);
            end else begin
               send_item(CHAR_NL, 1'b0);
            end
         end
         default: begin
            gen_string($urandom_range(0, 5), 1'b0);
            send_item(CHAR_BSLASH, 1'b0);
            do begin
               b = 8'($urandom_range(0, 255));
            end while (b == CHAR_N || b == CHAR_T || b == CHAR_QUOTE || b == CHAR_BSLASH
                       || b == CHAR_NL);
            send_item(b, 1'b0);
         end
      endcase
      // halted: none of these may give a result item
      repeat (40) send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
   endtask

   // directed opening: punctuation, NUL and 0xff in a word, brace splitting,
   // every escape, end of input in a comment, once between tokens and once
   // right after a word (two result items), a quote inside a comment
   logic [8:0] opening_text [27] = '{
      {1'b0, CHAR_NL}, {1'b0, CHAR_RBRACE}, {1'b0, CHAR_SEMI}, {1'b0, CHAR_RPAREN},
      {1'b0, 8'h00}, {1'b0, CHAR_SEMI}, {1'b0, 8'hFF}, {1'b0, CHAR_LBRACE},
      {1'b0, CHAR_LBRACE}, {1'b0, CHAR_QUOTE}, {1'b0, CHAR_BSLASH}, {1'b0, CHAR_N},
      {1'b0, CHAR_BSLASH}, {1'b0, CHAR_T}, {1'b0, CHAR_BSLASH}, {1'b0, CHAR_QUOTE},
      {1'b0, CHAR_BSLASH}, {1'b0, CHAR_BSLASH}, {1'b0, CHAR_QUOTE}, {1'b0, CHAR_HASH},
      {1'b1, 8'hA5}, {1'b1, 8'h5A}, {1'b0, 8'h77}, {1'b1, 8'hFF},
      {1'b0, CHAR_HASH}, {1'b0, CHAR_QUOTE}, {1'b0, CHAR_NL}
   };

   initial begin
      int   next_hold;
      logic paused;
      next_hold = 300;
      paused = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_text[i]) begin
         send_item(opening_text[i][7:0], opening_text[i][8]);
      end
      wait_drained();

      // random tokens, mostly well formed; receiver holds off twice
      // while items keep coming, sender drains once midway
      while (token_bytes < RANDOM_ITEMS) begin
         if (token_bytes >= next_hold) begin
            hold_toggle <= ~hold_toggle;
            next_hold += 400;
         end
         if (!paused && token_bytes >= RANDOM_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         random_token();
      end

      // tokens right at the length limit, no error yet
      wait_drained();
      gen_word(TOKEN_LIMIT);
      gen_string(TOKEN_LIMIT - 2, 1'b1);
      repeat (10) random_token();

      wait_drained();
      raise_fault();

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
